@@ sv/vco_pkg.sv @@
// ----------------------------------------------------------------------------
// vco_pkg
// Types and constants shared by the voxel column occlusion stage.
// ----------------------------------------------------------------------------
package vco_pkg;

    localparam int COL_W    = 9;
    localparam int HEIGHT_W = 8;
    localparam int COLOR_W  = 16;
    localparam int DEPTH_W  = 14;
    localparam int EYE_W    = 10;
    localparam int HOR_W    = 9;
    localparam int ROW_W    = 8;

    // signed (eye - terrain) times zero-extended depth
    localparam int DIFF_W = EYE_W + 1;
    localparam int PROD_W = DIFF_W + DEPTH_W + 1;
    localparam int FRAC_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_EYE_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd2;

    localparam logic [EYE_W-1:0]        RST_EYE_HEIGHT  = 10'd40;
    localparam logic signed [HOR_W-1:0] RST_HORIZON_ROW = 9'sd50;
    localparam logic [ROW_W-1:0]        RST_SCREEN_ROWS = 8'd200;

    localparam logic CMD_FRAME  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [COL_W-1:0]    column;
        logic [HEIGHT_W-1:0] terrain_height;
        logic [COLOR_W-1:0]  texel_color;
        logic [DEPTH_W-1:0]  inv_depth;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]   strip_column;
        logic [ROW_W-1:0]   strip_top;
        logic [ROW_W-1:0]   strip_bottom;
        logic [COLOR_W-1:0] strip_color;
    } t_out_item;

endpackage

@@ sv/vco_mem.sv @@
// ----------------------------------------------------------------------------
// vco_mem
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vco_mem #(
    parameter int DEPTH = 160,
    parameter int WIDTH = 18
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vco_proj.sv @@
// ----------------------------------------------------------------------------
// vco_proj
// Projection multiplier: (eye height - terrain) * inverse depth, registered.
// ----------------------------------------------------------------------------
module vco_proj import vco_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [EYE_W-1:0]         i_eye_height,
    input  t_in_item                 i_item,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [DIFF_W-1:0]  diff;
    logic signed [DEPTH_W:0]   depth_s;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  r_prod;

    assign diff    = $signed({1'b0, i_eye_height}) - $signed({3'b000, i_item.terrain_height});
    assign depth_s = $signed({1'b0, i_item.inv_depth});
    assign n_prod  = diff * depth_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ sv/voxel_column_occlusion.sv @@
// ----------------------------------------------------------------------------
// voxel_column_occlusion
// Occlusion and strip stage of a front-to-back voxel terrain renderer.
// ----------------------------------------------------------------------------
// Takes one item per clock. A sample's strip, if any, reaches the result register
// by way of the stage one registers. Stage one multiplies and reads the column
// memory; stage two projects, compares against the lowest drawn row and writes
// it back, with the last write forwarded to a following read of the same
// memory row. Columns are packed one, two or four to a memory row so that a
// valid bit per row fits in flops; a frame start clears all those bits together,
// so there is no clearing pass after reset or between frames. The input
// stalls only while a strip waits in the result register and stage one is full.
// Configuration may only be written while no item is in flight.
// ----------------------------------------------------------------------------
module voxel_column_occlusion import vco_pkg::*; #(
    parameter int COLUMNS = 320
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NEED   = (COLUMNS + 255) / 256;
    localparam int LANES  = (NEED <= 1) ? 1 : ((NEED <= 2) ? 2 : 4);
    localparam int LSH    = $clog2(LANES);
    localparam int LW     = (LANES > 1) ? LSH : 1;
    localparam int ROWS   = (COLUMNS + LANES - 1) / LANES;
    localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENT_W  = ROW_W + 1;
    localparam int WORD_W = LANES * ENT_W;
    localparam int SHR_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = SHR_W + 1;

    localparam logic [COL_W+1:0] COL_LIMIT = (COL_W + 2)'(COLUMNS);
    localparam logic [COL_W-1:0] LANE_MASK = COL_W'(LANES - 1);

    // configuration
    logic [EYE_W-1:0]        r_eye_height;
    logic signed [HOR_W-1:0] r_horizon_row;
    logic [ROW_W-1:0]        r_screen_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_height  <= RST_EYE_HEIGHT;
            r_horizon_row <= RST_HORIZON_ROW;
            r_screen_rows <= RST_SCREEN_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EYE_HEIGHT:  r_eye_height  <= i_cfg_data;
                CFG_HORIZON_ROW: r_horizon_row <= i_cfg_data[HOR_W-1:0];
                CFG_SCREEN_ROWS: r_screen_rows <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // stage one: accept, read, multiply
    logic             in_xfer;
    logic             s0_inrange;
    logic [COL_W-1:0] s0_row_w;
    logic [COL_W-1:0] s0_lane_w;
    logic [AW-1:0]    s0_addr;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign s0_inrange = {2'b00, i_in_item.column} < COL_LIMIT;
    assign s0_row_w   = i_in_item.column >> LSH;
    assign s0_lane_w  = i_in_item.column & LANE_MASK;
    assign s0_addr    = s0_inrange ? s0_row_w[AW-1:0] : '0;

    logic                     r_s1_valid;
    logic                     r_s1_cmd;
    logic                     r_s1_inrange;
    logic [COL_W-1:0]         r_s1_col;
    logic [COLOR_W-1:0]       r_s1_color;
    logic [AW-1:0]            r_s1_addr;
    logic [LW-1:0]            r_s1_lane;
    logic signed [PROD_W-1:0] s1_prod;
    logic [WORD_W-1:0]        mem_rdata;

    logic s1_adv;
    logic s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd     <= i_in_item.cmd;
            r_s1_inrange <= s0_inrange;
            r_s1_col     <= i_in_item.column;
            r_s1_color   <= i_in_item.texel_color;
            r_s1_addr    <= s0_addr;
            r_s1_lane    <= s0_lane_w[LW-1:0];
        end
    end

    vco_proj u_proj (
        .i_clk        (i_clk),
        .i_en         (in_xfer),
        .i_eye_height (r_eye_height),
        .i_item       (i_in_item),
        .o_prod       (s1_prod)
    );

    logic              mem_we;
    logic [WORD_W-1:0] n_wr_word;

    vco_mem #(
        .DEPTH (ROWS),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_wr_word),
        .i_re    (in_xfer),
        .i_raddr (s0_addr),
        .o_rdata (mem_rdata)
    );

    // stage two: project, compare, write back
    logic              r_fwd_valid;
    logic [AW-1:0]     r_fwd_addr;
    logic [WORD_W-1:0] r_fwd_word;
    logic [ROWS-1:0]   r_row_valid;

    logic                     row_ok;
    logic [WORD_W-1:0]        rd_word;
    logic [ENT_W-1:0]         entry;
    logic [ROW_W-1:0]         lowest;
    logic signed [SHR_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  row_s;
    logic                     below;
    logic [ROW_W-1:0]         new_row;
    logic                     hit;

    // take the last write when the memory read raced it
    assign rd_word = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_word : mem_rdata;
    assign row_ok  = r_row_valid[r_s1_addr];
    assign entry   = rd_word[r_s1_lane * ENT_W +: ENT_W];
    assign lowest  = (row_ok && entry[ENT_W-1]) ? entry[ROW_W-1:0] : r_screen_rows;

    assign shifted = s1_prod[PROD_W-1:FRAC_W];
    assign row_s   = $signed({shifted[SHR_W-1], shifted})
                   + $signed({{(SUM_W - HOR_W){r_horizon_row[HOR_W-1]}}, r_horizon_row});

    // a negative row clamps to zero
    assign below   = row_s[SUM_W-1] ? (lowest != '0)
                                    : (row_s[SUM_W-2:0] < (SUM_W - 1)'(lowest));
    assign new_row = row_s[SUM_W-1] ? '0 : row_s[ROW_W-1:0];

    assign hit = r_s1_valid && (r_s1_cmd == CMD_SAMPLE) && r_s1_inrange && below;

    assign s1_adv     = !o_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign mem_we     = s1_fire && hit;

    always_comb begin
        n_wr_word = rd_word;
        for (int k = 0; k < LANES; k++) begin
            if (LW'(k) == r_s1_lane) begin
                n_wr_word[k * ENT_W +: ENT_W] = {1'b1, new_row};
            end else begin
                // drop stale touched marks of a row not yet written this frame
                n_wr_word[k * ENT_W + ROW_W] = row_ok && rd_word[k * ENT_W + ROW_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (s1_fire && (r_s1_cmd == CMD_FRAME)) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (mem_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_word <= n_wr_word;
        end
    end

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_out_item.strip_column <= r_s1_col;
            r_out_item.strip_top    <= new_row;
            r_out_item.strip_bottom <= lowest;
            r_out_item.strip_color  <= r_s1_color;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ sv/vco_chk.sv @@
// ----------------------------------------------------------------------------
// vco_chk
// Port-level checks for the voxel column occlusion stage.
// ----------------------------------------------------------------------------
module vco_chk import vco_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_strip_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.strip_top < o_out_item.strip_bottom))
        else $error("strip top not above strip bottom");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with free result register");

endmodule

bind voxel_column_occlusion vco_chk u_vco_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ bench/occlusion_checker.sv @@
// ----------------------------------------------------------------------------
// occlusion_checker
// Watches the sample and strip channels of the occlusion stage, keeps its own
// copy of the column rows and registers, and checks every strip in order.
// ----------------------------------------------------------------------------
module occlusion_checker import vco_pkg::*; #(
    parameter int COLUMNS = 320
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_MAX = 10;

    logic [EYE_W-1:0]        eye_height;
    logic signed [HOR_W-1:0] horizon_row;
    logic [ROW_W-1:0]        screen_rows;
    logic [ROW_W-1:0]        lowest_row [COLUMNS];
    logic                    drawn      [COLUMNS];
    t_out_item               strips_due [$];
    int                      mismatches = 0;

    // Screen row of a sample: floor of the scaled height difference, clamped at 0
    function automatic int project_row(input t_in_item smp);
        int scaled;
        scaled = (int'(eye_height) - int'(smp.terrain_height)) * int'(smp.inv_depth);
        scaled = (scaled >>> FRAC_W) + int'(horizon_row);
        return (scaled < 0) ? 0 : scaled;
    endfunction

    function automatic string show(input t_out_item s);
        return $sformatf("col %0d rows %0d..%0d colour %h",
                         s.strip_column, s.strip_top, s.strip_bottom, s.strip_color);
    endfunction

    task automatic flag(input string what);
        if (mismatches < REPORT_MAX) begin
            $display("%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        int        row;
        int        bottom;
        if (!i_rst_n) begin
            eye_height  <= RST_EYE_HEIGHT;
            horizon_row <= RST_HORIZON_ROW;
            screen_rows <= RST_SCREEN_ROWS;
            for (int c = 0; c < COLUMNS; c++) drawn[c] <= 1'b0;
            strips_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EYE_HEIGHT:  eye_height  <= i_cfg_data[EYE_W-1:0];
                    CFG_HORIZON_ROW: horizon_row <= i_cfg_data[HOR_W-1:0];
                    CFG_SCREEN_ROWS: screen_rows <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (strips_due.size() == 0) begin
                    flag($sformatf("strip with none due: got %s", show(i_out_item)));
                end else begin
                    want = strips_due.pop_front();
                    if (i_out_item.strip_column !== want.strip_column ||
                        i_out_item.strip_top    !== want.strip_top    ||
                        i_out_item.strip_bottom !== want.strip_bottom ||
                        i_out_item.strip_color  !== want.strip_color) begin
                        flag($sformatf("strip mismatch: expected %s, got %s",
                                       show(want), show(i_out_item)));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.cmd == CMD_FRAME) begin
                    for (int c = 0; c < COLUMNS; c++) drawn[c] <= 1'b0;
                end else if (i_in_item.column < COLUMNS) begin
                    row    = project_row(i_in_item);
                    // an untouched column follows the current screen height
                    bottom = drawn[i_in_item.column] ? int'(lowest_row[i_in_item.column])
                                                     : int'(screen_rows);
                    if (row < bottom) begin
                        want.strip_column = i_in_item.column;
                        want.strip_top    = row[ROW_W-1:0];
                        want.strip_bottom = bottom[ROW_W-1:0];
                        want.strip_color  = i_in_item.texel_color;
                        strips_due.push_back(want);
                        lowest_row[i_in_item.column] <= row[ROW_W-1:0];
                        drawn[i_in_item.column]      <= 1'b1;
                    end
                end
            end
        end
        o_pending    <= strips_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives frame starts and terrain samples into the occlusion stage under
// several register settings, with bursty input and a stalling strip sink.
// ----------------------------------------------------------------------------
module testbench;
    import vco_pkg::*;

    localparam int COLUMNS    = 320;
    localparam int SETTLE     = 8;
    localparam int IDLE_LIMIT = 2000;

    typedef enum logic [1:0] {
        SINK_FLOW,
        SINK_SPARSE,
        SINK_RUNS,
        SINK_HEAVY
    } t_sink_mode;

    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    t_sink_mode sink_mode    = SINK_FLOW;
    int         mode_left    = 0;
    int         run_left     = 0;

    voxel_column_occlusion #(
        .COLUMNS (COLUMNS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    occlusion_checker #(
        .COLUMNS (COLUMNS)
    ) strip_check (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Strip sink: switch to a randomly chosen stall pattern each time a mode's run ends
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(100, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (sink_mode)
            SINK_FLOW:   out_stall <= 1'b0;
            SINK_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
            SINK_RUNS: begin
                if (run_left == 0) begin
                    out_stall <= ~out_stall;
                    run_left  <= $urandom_range(1, 12);
                end else begin
                    run_left <= run_left - 1;
                end
            end
            default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_in_item mk(input logic cmd, input int col, input int terrain,
                                    input int colour, input int depth);
        t_in_item it;
        it.cmd            = cmd;
        it.column         = col[COL_W-1:0];
        it.terrain_height = terrain[HEIGHT_W-1:0];
        it.texel_color    = colour[COLOR_W-1:0];
        it.inv_depth      = depth[DEPTH_W-1:0];
        return it;
    endfunction

    function automatic t_in_item random_item();
        return mk(1'($urandom_range(0, 1)), $urandom_range(0, 511), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom_range(0, 16383));
    endfunction

    // Hold valid until the transfer happens; return at the accepting edge
    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        in_valid <= 1'b0;
        in_item  <= random_item();
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait for every due strip, plus a settling pause
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input int eye, input int horizon, input int rows,
                              input logic [2:0] which);
        if (which[0]) put_reg(CFG_EYE_HEIGHT, CFG_DATA_W'(eye[EYE_W-1:0]));
        if (which[1]) put_reg(CFG_HORIZON_ROW, CFG_DATA_W'(horizon[HOR_W-1:0]));
        if (which[2]) put_reg(CFG_SCREEN_ROWS, CFG_DATA_W'(rows[ROW_W-1:0]));
        cfg_we <= 1'b0;
    endtask

    // Frames of front-to-back walks over a narrow band of columns, with noise
    task automatic random_phase(input int n_items, input bit open_frame);
        t_in_item it;
        int       sent;
        int       walk_left;
        int       base;
        int       depth;
        int       pick;
        int       burst;
        int       gap;
        sent      = 0;
        walk_left = open_frame ? 0 : $urandom_range(16, 96);
        base      = $urandom_range(0, COLUMNS - 16);
        depth     = $urandom_range(64, 12800);
        burst     = $urandom_range(1, 40);
        while (sent < n_items) begin
            if (walk_left == 0) begin
                it        = random_item();
                it.cmd    = CMD_FRAME;
                walk_left = $urandom_range(16, 96);
                base      = $urandom_range(0, COLUMNS - 16);
                depth     = $urandom_range(64, 12800);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    it    = mk(CMD_SAMPLE, base + $urandom_range(0, 15), $urandom_range(0, 255),
                               $urandom_range(0, 65535), depth);
                    depth = depth - $urandom_range(0, depth / 8 + 1);
                    if (depth < 8) depth = 8;
                end else if (pick < 85) begin
                    it        = random_item();
                    it.cmd    = CMD_SAMPLE;
                    it.column = COL_W'($urandom_range(COLUMNS, 511));
                end else if (pick < 88) begin
                    it     = random_item();
                    it.cmd = CMD_FRAME;
                end else begin
                    it        = random_item();
                    it.cmd    = CMD_SAMPLE;
                    it.column = COL_W'($urandom_range(0, COLUMNS - 1));
                end
                walk_left--;
            end
            send_item(it);
            if (it.cmd == CMD_FRAME || it.column < COLUMNS) sent++;
            burst--;
            if (burst == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) pause(gap);
                burst = $urandom_range(1, 40);
            end
        end
    endtask

    initial begin
        int eye;
        int horizon;
        int rows;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed items under the reset register values
        send_item(mk(CMD_FRAME, 0, 0, 0, 0));
        send_item(mk(CMD_SAMPLE, 0, 0, 'h0000, 0));
        send_item(mk(CMD_SAMPLE, 0, 255, 'h1234, 16383));
        send_item(mk(CMD_SAMPLE, 0, 0, 'hABCD, 0));
        send_item(mk(CMD_SAMPLE, 319, 0, 'h5555, 16383));
        send_item(mk(CMD_SAMPLE, 319, 40, 'hAAAA, 12800));
        send_item(mk(CMD_SAMPLE, 320, 0, 'hFFFF, 0));
        send_item(mk(CMD_SAMPLE, 511, 255, 'hFFFF, 16383));
        send_item(mk(CMD_SAMPLE, 1, 30, 'hFFFF, 256));
        send_item(mk(CMD_SAMPLE, 1, 35, 'h0F0F, 256));
        send_item(mk(CMD_SAMPLE, 1, 35, 'hF0F0, 256));
        // small negative products must round towards minus infinity
        send_item(mk(CMD_SAMPLE, 2, 41, 'h3C3C, 1));
        send_item(mk(CMD_SAMPLE, 2, 41, 'hC3C3, 255));
        send_item(mk(CMD_SAMPLE, 2, 42, 'h7E7E, 257));
        send_item(mk(CMD_FRAME, 511, 255, 'hFFFF, 16383));
        send_item(mk(CMD_SAMPLE, 1, 20, 'h8001, 5120));
        send_item(mk(CMD_SAMPLE, 1, 60, 'h7FFE, 5120));
        send_item(mk(CMD_SAMPLE, 0, 40, 'h1111, 16383));
        send_item(mk(CMD_SAMPLE, 255, 0, 'h2222, 12800));
        send_item(mk(CMD_SAMPLE, 256, 255, 'h0001, 12800));
        send_item(mk(CMD_SAMPLE, 170, 39, 'h9696, 12800));
        send_item(mk(CMD_SAMPLE, 85, 100, 'h6969, 700));
        drain();

        write_regs(0, 255, 240, 3'b111);
        random_phase(120, 1'b1);
        drain();
        // height changes with the frame still open
        write_regs(0, 0, 100, 3'b100);
        random_phase(120, 1'b0);
        drain();
        write_regs(0, 0, 0, 3'b100);
        random_phase(100, 1'b0);
        drain();
        write_regs(1023, -256, 1, 3'b111);
        random_phase(60, 1'b1);
        drain();
        write_regs(200, 0, 239, 3'b111);
        random_phase(120, 1'b1);
        drain();

        repeat (6) begin
            eye     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 300);
            horizon = int'($urandom_range(0, 511)) - 256;
            rows    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 240);
            write_regs(eye, horizon, rows, 3'($urandom_range(1, 7)));
            random_phase(110, 1'($urandom_range(0, 1)));
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
